@@ hw/rtl/aarm_pkg.sv @@
`default_nettype none
package aarm_pkg;

   localparam int SQRT_STEPS   = 32;
   localparam int DIV_STEPS    = 32;
   localparam int CORDIC_STEPS = 30;

   // CORDIC start value, pre-divided by the gain, Q30
   localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;

   // arctan(2^-i) on a 2^32 circle
   localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
   };

   // side band that rides along with each beat
   typedef struct packed {
      logic        zero;   // all axis components zero
      logic [2:0]  neg;    // component signs x, y, z
      logic [30:0] phase;  // half angle on a 2^32 circle
   } side_type;

endpackage
`default_nettype wire

@@ hw/rtl/axis_angle_rotation_matrix.sv @@
`default_nettype none
// Channel | Ports                                   | Dir | Beat content
// req     | req_valid/req_ready, req_axis_*, angle  | in  | axis x,y,z Q2.14, binary angle
// rsp     | rsp_valid/rsp_ready, rsp_m11..m33, zero | out | rotation entries Q2.14, flag
//
// Fully pipelined: one beat accepted per cycle while rsp does not stall.
// Depth is set by the restoring square root (32 stages) and the three-lane
// restoring divider (32 stages); the 30 CORDIC steps run inside the divider stages.
// Synchronous active-high reset clears the valid bits only.
// A stall on rsp freezes the whole pipe; req_ready drops in the same cycle.
module axis_angle_rotation_matrix #(
   parameter int COORD_BITS = 16,
   parameter int ANGLE_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [COORD_BITS-1:0] req_axis_x,
   input  logic signed [COORD_BITS-1:0] req_axis_y,
   input  logic signed [COORD_BITS-1:0] req_axis_z,
   input  logic        [ANGLE_BITS-1:0] req_angle,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [COORD_BITS-1:0] rsp_m11,
   output logic signed [COORD_BITS-1:0] rsp_m12,
   output logic signed [COORD_BITS-1:0] rsp_m13,
   output logic signed [COORD_BITS-1:0] rsp_m21,
   output logic signed [COORD_BITS-1:0] rsp_m22,
   output logic signed [COORD_BITS-1:0] rsp_m23,
   output logic signed [COORD_BITS-1:0] rsp_m31,
   output logic signed [COORD_BITS-1:0] rsp_m32,
   output logic signed [COORD_BITS-1:0] rsp_m33,
   output logic                         rsp_axis_zero
);

   localparam int SQ = aarm_pkg::SQRT_STEPS;
   localparam int DV = aarm_pkg::DIV_STEPS;
   localparam int OUT_SHIFT = 62 - COORD_BITS;
   localparam logic signed [63:0] RND   = 64'sd1 <<< (OUT_SHIFT - 1);
   localparam logic signed [63:0] LIM   = 64'sd1 <<< (COORD_BITS - 2);
   localparam logic signed [63:0] NLIM  = -LIM;
   localparam logic signed [63:0] ONE60 = 64'sd1 <<< 60;

   // global advance: the pipe moves whenever the output slot can take a beat
   logic en;
   logic out_vld_ff;
   assign en        = !out_vld_ff || rsp_ready;
   assign req_ready = en;

   // ---------------- P0: magnitudes, signs, phase
   logic                p0_vld_ff;
   logic [31:0]         p0_mag_ff [3];
   logic [31:0]         p0_max_ff;
   aarm_pkg::side_type  p0_side_ff;
   logic [31:0]         p0_mag_in [3];
   logic [31:0]         p0_max_in;
   aarm_pkg::side_type  p0_side_in;

   always_comb begin
      logic [COORD_BITS-1:0] raw [3];
      logic [COORD_BITS-1:0] mcb;
      logic [ANGLE_BITS+30:0] pw;
      raw[0] = req_axis_x;
      raw[1] = req_axis_y;
      raw[2] = req_axis_z;
      p0_max_in = '0;
      for (int i = 0; i < 3; i++) begin
         p0_side_in.neg[i] = raw[i][COORD_BITS-1];
         mcb = raw[i][COORD_BITS-1] ? (~raw[i] + 1'b1) : raw[i];
         p0_mag_in[i] = 32'(mcb);
         if (p0_mag_in[i] > p0_max_in) p0_max_in = p0_mag_in[i];
      end
      p0_side_in.zero = (p0_max_in == '0);
      pw = {req_angle, 31'b0} >> ANGLE_BITS;
      p0_side_in.phase = pw[30:0];
   end

   // ---------------- P1: pre-scale to 24 bits
   logic                p1_vld_ff;
   logic [23:0]         p1_mag_ff [3];
   aarm_pkg::side_type  p1_side_ff;
   logic [23:0]         p1_mag_in [3];

   always_comb begin
      logic [5:0]  bl;
      logic [3:0]  sh;
      logic [31:0] t;
      bl = '0;
      for (int b = 0; b < 32; b++) begin
         if (p0_max_ff[b]) bl = 6'(b + 1);
      end
      sh = (bl > 6'd24) ? 4'(bl - 6'd24) : 4'd0;
      for (int i = 0; i < 3; i++) begin
         t = p0_mag_ff[i] >> sh;
         p1_mag_in[i] = t[23:0];
      end
   end

   // ---------------- P2: sum of squares
   logic                p2_vld_ff;
   logic [49:0]         p2_s2_ff;
   logic [23:0]         p2_mag_ff [3];
   aarm_pkg::side_type  p2_side_ff;
   logic [49:0]         p2_s2_in;

   always_comb begin
      logic [47:0] sq [3];
      for (int i = 0; i < 3; i++) sq[i] = p1_mag_ff[i] * p1_mag_ff[i];
      p2_s2_in = 50'(sq[0]) + 50'(sq[1]) + 50'(sq[2]);
   end

   // ---------------- P3: scale by 4^k so that the radicand reaches 2^60
   logic [63:0] p3_v_in;
   logic [30:0] p3_mk_in [3];

   always_comb begin
      logic [5:0]  msb;
      logic [6:0]  kk;
      logic [4:0]  k;
      logic [63:0] t;
      msb = '0;
      for (int b = 0; b < 50; b++) begin
         if (p2_s2_ff[b]) msb = 6'(b);
      end
      kk = 7'd61 - 7'(msb);
      k  = kk[5:1];
      p3_v_in = 64'(p2_s2_ff) << {k, 1'b0};
      for (int i = 0; i < 3; i++) begin
         t = 64'(p2_mag_ff[i]) << k;
         p3_mk_in[i] = t[30:0];
      end
   end

   // ---------------- square root, one result bit per stage
   logic                sq_vld_ff  [SQ+1];
   logic [63:0]         sq_v_ff    [SQ+1];
   logic [63:0]         sq_r_ff    [SQ+1];
   logic [30:0]         sq_mk_ff   [SQ+1][3];
   aarm_pkg::side_type  sq_side_ff [SQ+1];
   logic [63:0]         sq_v_in    [SQ];
   logic [63:0]         sq_r_in    [SQ];

   always_comb begin
      logic [63:0] bitv;
      logic [63:0] trial;
      for (int j = 0; j < SQ; j++) begin
         bitv  = 64'd1 << (62 - 2 * j);
         trial = sq_r_ff[j] + bitv;
         if (sq_v_ff[j] >= trial) begin
            sq_v_in[j] = sq_v_ff[j] - trial;
            sq_r_in[j] = (sq_r_ff[j] >> 1) + bitv;
         end else begin
            sq_v_in[j] = sq_v_ff[j];
            sq_r_in[j] = sq_r_ff[j] >> 1;
         end
      end
   end

   // ---------------- divider setup and CORDIC start
   logic [31:0]        sq_n;
   logic [63:0]        d0_w_in [3];
   logic signed [32:0] d0_z_in;
   assign sq_n = sq_r_ff[SQ][31:0];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         d0_w_in[i] = {3'b0, sq_mk_ff[SQ][i], 30'b0} + 64'(sq_n[31:1]);
      end
      // quarter turn folded out: bit 30 of the phase is dropped here
      d0_z_in = $signed(33'(sq_side_ff[SQ].phase[29:0]));
   end

   // ---------------- divider lanes, CORDIC in the same stages
   logic                dv_vld_ff  [DV+1];
   logic [63:0]         dv_w_ff    [DV+1][3];
   logic [31:0]         dv_n_ff    [DV+1];
   logic signed [33:0]  dv_x_ff    [DV+1];
   logic signed [33:0]  dv_y_ff    [DV+1];
   logic signed [32:0]  dv_z_ff    [DV+1];
   aarm_pkg::side_type  dv_side_ff [DV+1];
   logic [63:0]         dv_w_in    [DV][3];
   logic signed [33:0]  dv_x_in    [DV];
   logic signed [33:0]  dv_y_in    [DV];
   logic signed [32:0]  dv_z_in    [DV];

   always_comb begin
      logic [32:0]        t;
      logic               qb;
      logic signed [33:0] dx;
      logic signed [33:0] dy;
      logic signed [32:0] at;
      for (int j = 0; j < DV; j++) begin
         for (int i = 0; i < 3; i++) begin
            t  = dv_w_ff[j][i][63:31];
            qb = (t >= {1'b0, dv_n_ff[j]});
            if (qb) t = t - {1'b0, dv_n_ff[j]};
            dv_w_in[j][i] = {t[31:0], dv_w_ff[j][i][30:0], qb};
         end
         dv_x_in[j] = dv_x_ff[j];
         dv_y_in[j] = dv_y_ff[j];
         dv_z_in[j] = dv_z_ff[j];
         if (j < aarm_pkg::CORDIC_STEPS) begin
            dx = dv_y_ff[j] >>> j;
            dy = dv_x_ff[j] >>> j;
            at = $signed({1'b0, aarm_pkg::ATAN_TAB[j]});
            if (!dv_z_ff[j][32]) begin
               dv_x_in[j] = dv_x_ff[j] - dx;
               dv_y_in[j] = dv_y_ff[j] + dy;
               dv_z_in[j] = dv_z_ff[j] - at;
            end else begin
               dv_x_in[j] = dv_x_ff[j] + dx;
               dv_y_in[j] = dv_y_ff[j] - dy;
               dv_z_in[j] = dv_z_ff[j] + at;
            end
         end
      end
   end

   // ---------------- M0: quaternion
   logic                m0_vld_ff;
   logic signed [33:0]  m0_q_ff [4];
   logic                m0_zero_ff;
   logic signed [33:0]  m0_q_in [4];

   always_comb begin
      logic signed [33:0] c;
      logic signed [33:0] s;
      logic signed [33:0] u;
      logic signed [67:0] prod;
      logic               quarter;
      quarter = dv_side_ff[DV].phase[30];
      c = quarter ? -dv_y_ff[DV] : dv_x_ff[DV];
      s = quarter ? dv_x_ff[DV]  : dv_y_ff[DV];
      m0_q_in[0] = c;
      for (int i = 0; i < 3; i++) begin
         u = dv_side_ff[DV].neg[i] ? -$signed(34'(dv_w_ff[DV][i][31:0]))
                                   : $signed(34'(dv_w_ff[DV][i][31:0]));
         prod = s * u;
         m0_q_in[i+1] = $signed(prod[63:30]);
      end
   end

   // ---------------- M1: pair products, Q60
   function automatic logic signed [63:0] mul(input logic signed [33:0] a,
                                              input logic signed [33:0] b);
      logic signed [67:0] p;
      p = a * b;
      return $signed(p[63:0]);
   endfunction

   logic                m1_vld_ff;
   logic signed [63:0]  m1_p_ff [9];
   logic                m1_zero_ff;
   logic signed [63:0]  m1_p_in [9];

   // order: aa bb dd ab ad bd wa wb wd
   always_comb begin
      m1_p_in[0] = mul(m0_q_ff[1], m0_q_ff[1]);
      m1_p_in[1] = mul(m0_q_ff[2], m0_q_ff[2]);
      m1_p_in[2] = mul(m0_q_ff[3], m0_q_ff[3]);
      m1_p_in[3] = mul(m0_q_ff[1], m0_q_ff[2]);
      m1_p_in[4] = mul(m0_q_ff[1], m0_q_ff[3]);
      m1_p_in[5] = mul(m0_q_ff[2], m0_q_ff[3]);
      m1_p_in[6] = mul(m0_q_ff[0], m0_q_ff[1]);
      m1_p_in[7] = mul(m0_q_ff[0], m0_q_ff[2]);
      m1_p_in[8] = mul(m0_q_ff[0], m0_q_ff[3]);
   end

   // ---------------- M2: matrix entries, Q60
   logic                m2_vld_ff;
   logic signed [63:0]  m2_e_ff [9];
   logic                m2_zero_ff;
   logic signed [63:0]  m2_e_in [9];

   always_comb begin
      m2_e_in[0] = ONE60 - ((m1_p_ff[1] + m1_p_ff[2]) <<< 1);
      m2_e_in[1] = (m1_p_ff[3] - m1_p_ff[8]) <<< 1;
      m2_e_in[2] = (m1_p_ff[4] + m1_p_ff[7]) <<< 1;
      m2_e_in[3] = (m1_p_ff[3] + m1_p_ff[8]) <<< 1;
      m2_e_in[4] = ONE60 - ((m1_p_ff[0] + m1_p_ff[2]) <<< 1);
      m2_e_in[5] = (m1_p_ff[5] - m1_p_ff[6]) <<< 1;
      m2_e_in[6] = (m1_p_ff[4] - m1_p_ff[7]) <<< 1;
      m2_e_in[7] = (m1_p_ff[5] + m1_p_ff[6]) <<< 1;
      m2_e_in[8] = ONE60 - ((m1_p_ff[0] + m1_p_ff[1]) <<< 1);
   end

   // ---------------- M3: round half up, saturate, identity on a zero axis
   logic signed [COORD_BITS-1:0] out_m_ff [9];
   logic                         out_zero_ff;
   logic signed [COORD_BITS-1:0] out_m_in [9];

   always_comb begin
      logic signed [63:0] r;
      for (int i = 0; i < 9; i++) begin
         r = (m2_e_ff[i] + RND) >>> OUT_SHIFT;
         if (m2_zero_ff)   out_m_in[i] = (i % 4 == 0) ? LIM[COORD_BITS-1:0] : '0;
         else if (r > LIM)  out_m_in[i] = LIM[COORD_BITS-1:0];
         else if (r < NLIM) out_m_in[i] = NLIM[COORD_BITS-1:0];
         else               out_m_in[i] = r[COORD_BITS-1:0];
      end
   end

   // ---------------- valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         p0_vld_ff  <= 1'b0;
         p1_vld_ff  <= 1'b0;
         p2_vld_ff  <= 1'b0;
         for (int j = 0; j <= SQ; j++) sq_vld_ff[j] <= 1'b0;
         for (int j = 0; j <= DV; j++) dv_vld_ff[j] <= 1'b0;
         m0_vld_ff  <= 1'b0;
         m1_vld_ff  <= 1'b0;
         m2_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (en) begin
         p0_vld_ff    <= req_valid;
         p1_vld_ff    <= p0_vld_ff;
         p2_vld_ff    <= p1_vld_ff;
         sq_vld_ff[0] <= p2_vld_ff;
         for (int j = 0; j < SQ; j++) sq_vld_ff[j+1] <= sq_vld_ff[j];
         dv_vld_ff[0] <= sq_vld_ff[SQ];
         for (int j = 0; j < DV; j++) dv_vld_ff[j+1] <= dv_vld_ff[j];
         m0_vld_ff    <= dv_vld_ff[DV];
         m1_vld_ff    <= m0_vld_ff;
         m2_vld_ff    <= m1_vld_ff;
         out_vld_ff   <= m2_vld_ff;
      end
   end

   // ---------------- payload
   always_ff @(posedge clock) begin
      if (en) begin
         p0_mag_ff  <= p0_mag_in;
         p0_max_ff  <= p0_max_in;
         p0_side_ff <= p0_side_in;

         p1_mag_ff  <= p1_mag_in;
         p1_side_ff <= p0_side_ff;

         p2_s2_ff   <= p2_s2_in;
         p2_mag_ff  <= p1_mag_ff;
         p2_side_ff <= p1_side_ff;

         sq_v_ff[0]    <= p3_v_in;
         sq_r_ff[0]    <= '0;
         sq_mk_ff[0]   <= p3_mk_in;
         sq_side_ff[0] <= p2_side_ff;
         for (int j = 0; j < SQ; j++) begin
            sq_v_ff[j+1]    <= sq_v_in[j];
            sq_r_ff[j+1]    <= sq_r_in[j];
            sq_mk_ff[j+1]   <= sq_mk_ff[j];
            sq_side_ff[j+1] <= sq_side_ff[j];
         end

         dv_w_ff[0]    <= d0_w_in;
         dv_n_ff[0]    <= sq_n;
         dv_x_ff[0]    <= aarm_pkg::CORDIC_X0;
         dv_y_ff[0]    <= '0;
         dv_z_ff[0]    <= d0_z_in;
         dv_side_ff[0] <= sq_side_ff[SQ];
         for (int j = 0; j < DV; j++) begin
            dv_w_ff[j+1]    <= dv_w_in[j];
            dv_n_ff[j+1]    <= dv_n_ff[j];
            dv_x_ff[j+1]    <= dv_x_in[j];
            dv_y_ff[j+1]    <= dv_y_in[j];
            dv_z_ff[j+1]    <= dv_z_in[j];
            dv_side_ff[j+1] <= dv_side_ff[j];
         end

         m0_q_ff    <= m0_q_in;
         m0_zero_ff <= dv_side_ff[DV].zero;
         m1_p_ff    <= m1_p_in;
         m1_zero_ff <= m0_zero_ff;
         m2_e_ff    <= m2_e_in;
         m2_zero_ff <= m1_zero_ff;
         out_m_ff    <= out_m_in;
         out_zero_ff <= m2_zero_ff;
      end
   end

   assign rsp_valid     = out_vld_ff;
   assign rsp_m11       = out_m_ff[0];
   assign rsp_m12       = out_m_ff[1];
   assign rsp_m13       = out_m_ff[2];
   assign rsp_m21       = out_m_ff[3];
   assign rsp_m22       = out_m_ff[4];
   assign rsp_m23       = out_m_ff[5];
   assign rsp_m31       = out_m_ff[6];
   assign rsp_m32       = out_m_ff[7];
   assign rsp_m33       = out_m_ff[8];
   assign rsp_axis_zero = out_zero_ff;

   // ---------------- checks
   // normalised radicand must give a root in [2^30, 2^31)
   a_root_range: assert property (@(posedge clock) disable iff (reset)
      sq_vld_ff[SQ] && !sq_side_ff[SQ].zero |->
         sq_r_ff[SQ][63:31] == '0 && sq_r_ff[SQ][30])
      else $error("square root out of range");

   // unit components never reach 2^31
   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      dv_vld_ff[DV] && !dv_side_ff[DV].zero |->
         !dv_w_ff[DV][0][31] && !dv_w_ff[DV][1][31] && !dv_w_ff[DV][2][31])
      else $error("unit axis component too large");

   // zero axis gives the identity
   a_identity: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_axis_zero |->
         rsp_m11 == LIM[COORD_BITS-1:0] && rsp_m22 == LIM[COORD_BITS-1:0] &&
         rsp_m12 == '0 && rsp_m23 == '0 && rsp_m31 == '0)
      else $error("zero axis without identity");

   // a stalled result stays valid and the M2 entries hold while the pipe is frozen
   a_frozen: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(m2_e_ff[0]))
      else $error("pipe moved during stall");

endmodule
`default_nettype wire

@@ tb/rotation_checker.sv @@
`default_nettype none
module rotation_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic signed [15:0] req_axis_x,
   input  logic signed [15:0] req_axis_y,
   input  logic signed [15:0] req_axis_z,
   input  logic        [15:0] req_angle,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic signed [15:0] rsp_m11,
   input  logic signed [15:0] rsp_m12,
   input  logic signed [15:0] rsp_m13,
   input  logic signed [15:0] rsp_m21,
   input  logic signed [15:0] rsp_m22,
   input  logic signed [15:0] rsp_m23,
   input  logic signed [15:0] rsp_m31,
   input  logic signed [15:0] rsp_m32,
   input  logic signed [15:0] rsp_m33,
   input  logic               rsp_axis_zero,
   output int                 fail_count,
   output int                 matrices_owed
);

   typedef struct {
      logic [15:0] m [9];
      logic        zero;
   } rotation_type;

   rotation_type owed_q [$];

   function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
      logic [63:0] res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   // Q60 to Q2.14, round half up, clamp to +/-1.0
   function automatic logic [15:0] to_q14(input longint v);
      longint r;
      r = (v + (longint'(1) <<< 45)) >>> 46;
      if (r > 16384) r = 16384;
      if (r < -16384) r = -16384;
      return r[15:0];
   endfunction

   function automatic rotation_type predict_rotation(input logic [15:0] ax,
                                                     input logic [15:0] ay,
                                                     input logic [15:0] az,
                                                     input logic [15:0] ang);
      rotation_type r;
      logic [15:0] raw [3];
      logic [63:0] mag [3];
      logic [63:0] maxm, s2, n, p, t;
      logic        neg [3];
      longint      u [3];
      longint      cx, cy, cz, dx, dy, c, s, w, a, b, d, one;
      int          k;
      raw = '{ax, ay, az};
      maxm = 0;
      for (int i = 0; i < 3; i++) begin
         neg[i] = raw[i][15];
         mag[i] = neg[i] ? 64'd65536 - 64'(raw[i]) : 64'(raw[i]);
         if (mag[i] > maxm) maxm = mag[i];
      end
      if (maxm == 0) begin
         for (int i = 0; i < 9; i++) r.m[i] = (i % 4 == 0) ? 16'd16384 : 16'd0;
         r.zero = 1'b1;
         return r;
      end
      // 16-bit components never need the 24-bit pre-scale
      s2 = 0;
      for (int i = 0; i < 3; i++) s2 = s2 + mag[i] * mag[i];
      k = 0;
      while (s2 < (64'd1 << 60)) begin
         s2 = s2 << 2;
         k++;
      end
      n = floor_sqrt(s2);
      for (int i = 0; i < 3; i++) begin
         t = ((mag[i] << (30 + k)) + (n >> 1)) / n;
         u[i] = neg[i] ? -longint'(t) : longint'(t);
      end
      p = 64'(ang) << 15;
      cx = longint'(aarm_pkg::CORDIC_X0);
      cy = 0;
      cz = (p >= (64'd1 << 30)) ? longint'(p - (64'd1 << 30)) : longint'(p);
      for (int i = 0; i < aarm_pkg::CORDIC_STEPS; i++) begin
         dx = cy >>> i;
         dy = cx >>> i;
         if (cz >= 0) begin
            cx -= dx; cy += dy; cz -= longint'(aarm_pkg::ATAN_TAB[i]);
         end else begin
            cx += dx; cy -= dy; cz += longint'(aarm_pkg::ATAN_TAB[i]);
         end
      end
      if (p >= (64'd1 << 30)) begin
         c = -cy; s = cx;
      end else begin
         c = cx; s = cy;
      end
      w = c;
      a = (s * u[0]) >>> 30;
      b = (s * u[1]) >>> 30;
      d = (s * u[2]) >>> 30;
      one = longint'(1) <<< 60;
      r.m[0] = to_q14(one - 2 * (b * b + d * d));
      r.m[1] = to_q14(2 * (a * b - w * d));
      r.m[2] = to_q14(2 * (a * d + w * b));
      r.m[3] = to_q14(2 * (a * b + w * d));
      r.m[4] = to_q14(one - 2 * (a * a + d * d));
      r.m[5] = to_q14(2 * (b * d - w * a));
      r.m[6] = to_q14(2 * (a * d - w * b));
      r.m[7] = to_q14(2 * (b * d + w * a));
      r.m[8] = to_q14(one - 2 * (a * a + b * b));
      r.zero = 1'b0;
      return r;
   endfunction

   assign matrices_owed = owed_q.size();

   always @(posedge clock) begin
      rotation_type want;
      logic [15:0]  got [9];
      int           errs;
      errs = 0;
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (req_valid && req_ready)
            owed_q.push_back(predict_rotation(req_axis_x, req_axis_y, req_axis_z, req_angle));
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_m11, rsp_m12, rsp_m13, rsp_m21, rsp_m22, rsp_m23,
                    rsp_m31, rsp_m32, rsp_m33};
            if (owed_q.size() == 0) begin
               $display("%0t: unexpected rsp beat", $time);
               errs++;
            end else begin
               want = owed_q.pop_front();
               for (int i = 0; i < 9; i++)
                  if (got[i] !== want.m[i]) begin
                     $display("%0t: m%0d%0d expected %0d actual %0d", $time, i / 3 + 1,
                              i % 3 + 1, $signed(want.m[i]), $signed(got[i]));
                     errs++;
                  end
               if (rsp_axis_zero !== want.zero) begin
                  $display("%0t: axis_zero expected %0b actual %0b", $time, want.zero,
                           rsp_axis_zero);
                  errs++;
               end
            end
         end
         fail_count <= fail_count + errs;
      end
   end
endmodule
`default_nettype wire

@@ tb/tb.sv @@
`default_nettype none
module tb;
   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic signed [15:0] req_axis_x = '0;
   logic signed [15:0] req_axis_y = '0;
   logic signed [15:0] req_axis_z = '0;
   logic        [15:0] req_angle = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [15:0] rsp_m11, rsp_m12, rsp_m13, rsp_m21, rsp_m22, rsp_m23;
   logic signed [15:0] rsp_m31, rsp_m32, rsp_m33;
   logic               rsp_axis_zero;
   int                 fail_count;
   int                 matrices_owed;

   // idling odds in percent, changed per phase by the stimulus
   int                 send_idle_pct = 0;
   int                 recv_stall_pct = 0;
   logic               hold_off_go = 1'b0;
   int                 quiet_cycles = 0;

   localparam int QUIET_LIMIT = 5000;

   always #2 clock = ~clock;

   axis_angle_rotation_matrix dut (.*);

   rotation_checker checker_i (.*);

   // receiver: random stalls, plus one long hold-off counted here so the
   // pipe freezes and req_ready drops while beats keep being offered
   always @(posedge clock) begin
      static int  hold_left = 0;
      static bit  hold_used = 0;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (hold_off_go && !hold_used) begin
            hold_used = 1;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // watchdog on cycles with no beat on either channel
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("axis_angle_rotation_matrix test failed");
         $finish;
      end
   end

   // offer one beat and hold it until taken; then idle for a geometric
   // number of cycles so the sender sits idle in about pct of its cycles
   task automatic send_beat(input logic [15:0] x, input logic [15:0] y,
                            input logic [15:0] z, input logic [15:0] ang);
      req_valid  <= 1'b1;
      req_axis_x <= x;
      req_axis_y <= y;
      req_axis_z <= z;
      req_angle  <= ang;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
   endtask

   // mix of full range, half range, short, extreme and zero components
   function automatic logic [15:0] pick_component();
      int sel;
      sel = $urandom_range(9);
      case (sel)
         0:       return 16'h0000;
         1:       return 16'(int'($urandom_range(16)) - 8);
         2:       return $urandom_range(1) ? 16'h8000 : 16'h7FFF;
         3, 4:    return 16'(int'($urandom_range(32768)) - 16384);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic random_phase(input int beats, input int idle_pct, input int stall_pct);
      logic [15:0] x, y, z;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      repeat (beats) begin
         x = pick_component();
         y = pick_component();
         z = pick_component();
         send_beat(x, y, z, 16'($urandom));
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: zero axis, axis extremes, quadrant edges of the angle
      send_beat(16'h0000, 16'h0000, 16'h0000, 16'h1234);
      send_beat(16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
      send_beat(16'h4000, 16'h0000, 16'h0000, 16'h4000);
      send_beat(16'h0000, 16'h4000, 16'h0000, 16'h8000);
      send_beat(16'h0000, 16'h0000, 16'h4000, 16'hC000);
      send_beat(16'h8000, 16'h8000, 16'h8000, 16'h0000);
      send_beat(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF);
      send_beat(16'h8000, 16'h7FFF, 16'h0000, 16'h7FFF);
      send_beat(16'h0001, 16'h0000, 16'h0000, 16'h8001);
      send_beat(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h3FFF);
      send_beat(16'h0001, 16'h0001, 16'h0001, 16'h0001);
      send_beat(16'h8000, 16'h0000, 16'h0000, 16'hBFFF);
      send_beat(16'h0000, 16'h7FFF, 16'h8000, 16'h4001);
      send_beat(16'h5555, 16'hAAAA, 16'h1234, 16'hAAAA);
      send_beat(16'hAAAA, 16'h5555, 16'hEDCB, 16'h5555);

      random_phase(400, 0, 0);
      random_phase(400, 46, 0);
      random_phase(400, 0, 46);
      // long receiver hold-off while the sender keeps going
      hold_off_go <= 1'b1;
      random_phase(400, 17, 17);

      req_valid <= 1'b0;
      while (matrices_owed != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (fail_count == 0)
         $display("axis_angle_rotation_matrix test passed");
      else
         $display("axis_angle_rotation_matrix test failed");
      $finish;
   end
endmodule
`default_nettype wire

@@ axis_angle_rotation_matrix.f @@
hw/rtl/aarm_pkg.sv
hw/rtl/axis_angle_rotation_matrix.sv
tb/rotation_checker.sv
tb/tb.sv
